FILE: sv/rhm_pkg.sv
// Shared types for the two-heap running median block.
package rhm_pkg;

  typedef enum logic {
    HEAP_LOWER,
    HEAP_UPPER
  } heap_sel_t;

  typedef enum logic {
    OP_PUSH,
    OP_POP
  } heap_op_t;

  typedef struct packed {
    logic      go;
    heap_op_t  op;
    heap_sel_t sel;
  } heap_cmd_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_PUSH_CMP,
    E_PUSH_FIN,
    E_POP_LAST,
    E_POP_C,
    E_POP_C0,
    E_POP_C1,
    E_POP_DEC
  } eng_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_PUSH1,
    C_WAIT1,
    C_POP,
    C_WAIT_POP,
    C_PUSH2,
    C_WAIT2,
    C_RESULT
  } ctl_state_t;

endpackage

FILE: sv/rhm_if.sv
// Stream interfaces for samples in and median results out.
interface rhm_in_if #(
  parameter int SW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface rhm_out_if #(
  parameter int SW = 32,
  parameter int CW = 10
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] median_value;
  logic        [CW-1:0] sample_count;
  logic                 sample_dropped;

  modport source (output valid, output median_value, output sample_count,
                  output sample_dropped, input ready);
  modport sink (input valid, input median_value, input sample_count,
                input sample_dropped, output ready);
endinterface

FILE: sv/rhm_ram.sv
// Generic simple dual-port RAM with registered read.
module rhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

FILE: sv/rhm_heap_engine.sv
// Heap push/pop sequencer over the two heap memories, with counts and cached tops.
module rhm_heap_engine
  import rhm_pkg::*;
#(
  parameter int HEAP_DEPTH   = 512,
  parameter int SAMPLE_WIDTH = 32,
  parameter int AW = $clog2(HEAP_DEPTH),
  parameter int HW = $clog2(HEAP_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  heap_cmd_t                      cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] cmd_value,
  output logic                           busy,
  output logic        [HW-1:0]           lower_count,
  output logic        [HW-1:0]           upper_count,
  output logic signed [SAMPLE_WIDTH-1:0] lower_top,
  output logic signed [SAMPLE_WIDTH-1:0] upper_top,
  output logic signed [SAMPLE_WIDTH-1:0] popped
);
  localparam int EW = (AW + 2 > HW + 1) ? AW + 2 : HW + 1;

  eng_state_t state_r, state_nxt;
  heap_sel_t  sel_r, sel_nxt;
  logic signed [SAMPLE_WIDTH-1:0] val_r, val_nxt, hc_r, hc_nxt, popped_r, popped_nxt;
  logic signed [SAMPLE_WIDTH-1:0] ltop_r, ltop_nxt, utop_r, utop_nxt;
  logic [AW-1:0] idx_r, idx_nxt, ic_r, ic_nxt;
  logic [HW-1:0] cnt_r, cnt_nxt, lc_r, lc_nxt, uc_r, uc_nxt;

  logic                    wr_en, rd_en;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic [SAMPLE_WIDTH-1:0] wr_data;
  logic [SAMPLE_WIDTH-1:0] lo_rdata, up_rdata;
  logic signed [SAMPLE_WIDTH-1:0] rdata;

  logic [HW-1:0] n_sel;
  logic [AW-1:0] parent, parent2, ic_inc;
  logic [EW-1:0] child_ext, ic_inc_ext, cnt_ext;

  function automatic logic above(input logic signed [SAMPLE_WIDTH-1:0] a,
                                 input logic signed [SAMPLE_WIDTH-1:0] b,
                                 input heap_sel_t s);
    return (s == HEAP_LOWER) ? (a > b) : (a < b);
  endfunction

  assign rdata      = $signed((sel_r == HEAP_LOWER) ? lo_rdata : up_rdata);
  assign n_sel      = (cmd.sel == HEAP_LOWER) ? lc_r : uc_r;
  assign parent     = (idx_r - AW'(1)) >> 1;
  assign parent2    = (parent - AW'(1)) >> 1;
  assign ic_inc     = ic_r + AW'(1);
  assign child_ext  = EW'({idx_r, 1'b1});
  assign ic_inc_ext = EW'(ic_r) + EW'(1);
  assign cnt_ext    = EW'(cnt_r);

  // Next state and register updates.
  always_comb begin
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    val_nxt    = val_r;
    hc_nxt     = hc_r;
    popped_nxt = popped_r;
    idx_nxt    = idx_r;
    ic_nxt     = ic_r;
    cnt_nxt    = cnt_r;
    lc_nxt     = lc_r;
    uc_nxt     = uc_r;
    case (state_r)
      E_IDLE: begin
        if (cmd.go) begin
          sel_nxt = cmd.sel;
          if (cmd.op == OP_PUSH) begin
            val_nxt = cmd_value;
            idx_nxt = n_sel[AW-1:0];
            state_nxt = (n_sel == '0) ? E_PUSH_FIN : E_PUSH_CMP;
            if (cmd.sel == HEAP_LOWER) lc_nxt = lc_r + HW'(1);
            else                       uc_nxt = uc_r + HW'(1);
          end else begin
            popped_nxt = (cmd.sel == HEAP_LOWER) ? ltop_r : utop_r;
            cnt_nxt = n_sel - HW'(1);
            idx_nxt = '0;
            state_nxt = E_POP_LAST;
            if (cmd.sel == HEAP_LOWER) lc_nxt = lc_r - HW'(1);
            else                       uc_nxt = uc_r - HW'(1);
          end
        end
      end
      E_PUSH_CMP: begin
        if (!above(val_r, rdata, sel_r)) begin
          state_nxt = E_IDLE;
        end else begin
          idx_nxt = parent;
          if (parent == '0) state_nxt = E_PUSH_FIN;
        end
      end
      E_PUSH_FIN: state_nxt = E_IDLE;
      E_POP_LAST: begin
        val_nxt = rdata;
        state_nxt = (cnt_r == '0) ? E_IDLE : E_POP_C;
      end
      E_POP_C: begin
        if (child_ext >= cnt_ext) begin
          state_nxt = E_IDLE;
        end else begin
          ic_nxt = child_ext[AW-1:0];
          state_nxt = E_POP_C0;
        end
      end
      E_POP_C0: begin
        hc_nxt = rdata;
        state_nxt = (ic_inc_ext < cnt_ext) ? E_POP_C1 : E_POP_DEC;
      end
      E_POP_C1: begin
        if (above(rdata, hc_r, sel_r)) begin
          hc_nxt = rdata;
          ic_nxt = ic_inc;
        end
        state_nxt = E_POP_DEC;
      end
      E_POP_DEC: begin
        if (!above(hc_r, val_r, sel_r)) begin
          state_nxt = E_IDLE;
        end else begin
          idx_nxt = ic_r;
          state_nxt = E_POP_C;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = val_r;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state_r)
      E_IDLE: begin
        if (cmd.go) begin
          rd_en = 1'b1;
          if (cmd.op == OP_PUSH) rd_addr = (n_sel[AW-1:0] - AW'(1)) >> 1;
          else                   rd_addr = AW'(n_sel - HW'(1));
        end
      end
      E_PUSH_CMP: begin
        wr_en = 1'b1;
        if (above(val_r, rdata, sel_r)) begin
          wr_data = rdata;
          rd_en   = (parent != '0);
          rd_addr = parent2;
        end
      end
      E_PUSH_FIN: wr_en = 1'b1;
      E_POP_LAST: ;
      E_POP_C: begin
        if (child_ext >= cnt_ext) begin
          wr_en = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = child_ext[AW-1:0];
        end
      end
      E_POP_C0: begin
        rd_en   = (ic_inc_ext < cnt_ext);
        rd_addr = ic_inc;
      end
      E_POP_C1: ;
      E_POP_DEC: begin
        wr_en = 1'b1;
        if (above(hc_r, val_r, sel_r)) wr_data = hc_r;
      end
      default: ;
    endcase
  end

  // The tops are mirrored in registers so that the placement compare and the median need no read.
  always_comb begin
    ltop_nxt = ltop_r;
    utop_nxt = utop_r;
    if (wr_en && wr_addr == '0) begin
      if (sel_r == HEAP_LOWER) ltop_nxt = $signed(wr_data);
      else                     utop_nxt = $signed(wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      lc_r    <= '0;
      uc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      lc_r    <= lc_nxt;
      uc_r    <= uc_nxt;
    end
    sel_r    <= sel_nxt;
    val_r    <= val_nxt;
    hc_r     <= hc_nxt;
    popped_r <= popped_nxt;
    idx_r    <= idx_nxt;
    ic_r     <= ic_nxt;
    cnt_r    <= cnt_nxt;
    ltop_r   <= ltop_nxt;
    utop_r   <= utop_nxt;
  end

  rhm_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HEAP_DEPTH)) u_lower_ram (
    .clk     (clk),
    .wr_en   (wr_en && sel_r == HEAP_LOWER),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (lo_rdata)
  );

  rhm_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HEAP_DEPTH)) u_upper_ram (
    .clk     (clk),
    .wr_en   (wr_en && sel_r == HEAP_UPPER),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (up_rdata)
  );

  assign busy        = (state_r != E_IDLE);
  assign lower_count = lc_r;
  assign upper_count = uc_r;
  assign lower_top   = ltop_r;
  assign upper_top   = utop_r;
  assign popped      = popped_r;
endmodule

FILE: sv/two_heap_running_median.sv
// Top level of the two-heap running median block.
// Each sample beat is placed in a max-heap (lower half) or a min-heap (upper
// half), or dropped when the heaps are full; the heaps are rebalanced, and
// one result beat carries the running median, the count and a drop flag.
// Both heaps live in single-port-read RAMs and all sifting runs through one
// shared sequencer, one level per cycle on a push; on a pop each level reads
// the children in turn, picks the one nearer the top and writes. The worst
// item pushes, pops and pushes again across nearly full heaps; its path from
// acceptance to its result beat and the next accept is set by the sift loops
// and their one memory read per cycle. A dropped sample skips the heaps. One
// sample is in flight at a time, and a result beat that is not taken holds
// off the next sample's result. There is no clearing pass after reset.
module two_heap_running_median
  import rhm_pkg::*;
#(
  parameter int HEAP_DEPTH   = 512,
  parameter int SAMPLE_WIDTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  rhm_in_if.sink   in_chan,
  rhm_out_if.source out_chan
);
  localparam int HW = $clog2(HEAP_DEPTH + 1);
  localparam int CW = $clog2(2 * HEAP_DEPTH);

  ctl_state_t state_r, state_nxt;
  logic signed [SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic                           drop_r, drop_nxt;
  heap_sel_t                      rb_sel_r, rb_sel_nxt;

  logic signed [SAMPLE_WIDTH-1:0] med_r, med_nxt;
  logic        [CW-1:0]           cnt_r, cnt_nxt;
  logic                           odrop_r, odrop_nxt, ovalid_r, ovalid_nxt;

  heap_cmd_t                      cmd;
  logic signed [SAMPLE_WIDTH-1:0] cmd_value;
  logic                           busy;
  logic [HW-1:0]                  lc, uc;
  logic signed [SAMPLE_WIDTH-1:0] ltop, utop, popped, avg;
  logic [CW-1:0]                  total;

  assign total = CW'(lc) + CW'(uc);
  assign avg   = $signed(ltop & utop) + ($signed(ltop ^ utop) >>> 1);

  always_comb begin
    state_nxt  = state_r;
    sample_nxt = sample_r;
    drop_nxt   = drop_r;
    rb_sel_nxt = rb_sel_r;
    case (state_r)
      C_IDLE: begin
        if (in_chan.valid) begin
          sample_nxt = in_chan.sample_value;
          drop_nxt   = (total >= CW'(2 * HEAP_DEPTH - 1));
          state_nxt  = (total >= CW'(2 * HEAP_DEPTH - 1)) ? C_RESULT : C_PUSH1;
        end
      end
      C_PUSH1: state_nxt = C_WAIT1;
      C_WAIT1: begin
        if (!busy) begin
          if (lc > uc + HW'(1)) begin
            rb_sel_nxt = HEAP_LOWER;
            state_nxt  = C_POP;
          end else if (lc < uc) begin
            rb_sel_nxt = HEAP_UPPER;
            state_nxt  = C_POP;
          end else begin
            state_nxt = C_RESULT;
          end
        end
      end
      C_POP:      state_nxt = C_WAIT_POP;
      C_WAIT_POP: if (!busy) state_nxt = C_PUSH2;
      C_PUSH2:    state_nxt = C_WAIT2;
      C_WAIT2:    if (!busy) state_nxt = C_RESULT;
      C_RESULT:   if (!ovalid_r || out_chan.ready) state_nxt = C_IDLE;
      default:    state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '{go: 1'b0, op: OP_PUSH, sel: HEAP_LOWER};
    cmd_value  = sample_r;
    med_nxt    = med_r;
    cnt_nxt    = cnt_r;
    odrop_nxt  = odrop_r;
    ovalid_nxt = ovalid_r && !out_chan.ready;
    case (state_r)
      C_PUSH1: begin
        cmd.go  = 1'b1;
        cmd.sel = (lc == '0 || ltop >= sample_r) ? HEAP_LOWER : HEAP_UPPER;
      end
      C_POP: begin
        cmd.go  = 1'b1;
        cmd.op  = OP_POP;
        cmd.sel = rb_sel_r;
      end
      C_PUSH2: begin
        cmd.go    = 1'b1;
        cmd.sel   = (rb_sel_r == HEAP_LOWER) ? HEAP_UPPER : HEAP_LOWER;
        cmd_value = popped;
      end
      C_RESULT: begin
        if (!ovalid_r || out_chan.ready) begin
          ovalid_nxt = 1'b1;
          cnt_nxt    = total;
          odrop_nxt  = drop_r;
          if (lc == '0)      med_nxt = '0;
          else if (lc != uc) med_nxt = ltop;
          else               med_nxt = avg;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= C_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    sample_r <= sample_nxt;
    drop_r   <= drop_nxt;
    rb_sel_r <= rb_sel_nxt;
    med_r    <= med_nxt;
    cnt_r    <= cnt_nxt;
    odrop_r  <= odrop_nxt;
  end

  rhm_heap_engine #(.HEAP_DEPTH(HEAP_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cmd_value   (cmd_value),
    .busy        (busy),
    .lower_count (lc),
    .upper_count (uc),
    .lower_top   (ltop),
    .upper_top   (utop),
    .popped      (popped)
  );

  assign in_chan.ready           = (state_r == C_IDLE);
  assign out_chan.valid          = ovalid_r;
  assign out_chan.median_value   = med_r;
  assign out_chan.sample_count   = cnt_r;
  assign out_chan.sample_dropped = odrop_r;
endmodule

FILE: tb/tb_two_heap_running_median.sv
// Self-checking testbench for the two-heap running median block.
module tb_two_heap_running_median;
  import rhm_pkg::*;

  localparam int SW       = 32;
  localparam int CW       = 10;
  localparam int CAPACITY = 2 * 512 - 1;

  typedef struct {
    logic signed [SW-1:0] median_value;
    logic        [CW-1:0] sample_count;
    logic                 sample_dropped;
  } median_beat_t;

  logic clk;
  logic rst_n;

  rhm_in_if  #(.SW(SW))          in_chan ();
  rhm_out_if #(.SW(SW), .CW(CW)) out_chan ();

  two_heap_running_median dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic signed [SW-1:0] samples_to_send[$];
  median_beat_t         medians_due[$];
  longint               held_sorted[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  send_paused;
  bit  recv_hold;
  int  mismatches;
  int  results_seen;
  int  drops_seen;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Keeps every sample held so far in ascending order; the lower heap's top
  // is the middle element (lower of the two for an even count).
  function automatic median_beat_t predict_median(logic signed [SW-1:0] s);
    median_beat_t r;
    int           n;
    int           k;
    int           pos;
    longint       v;
    v = s;
    r.sample_dropped = 1'b0;
    if (held_sorted.size() >= CAPACITY) begin
      r.sample_dropped = 1'b1;
    end else begin
      pos = held_sorted.size();
      while (pos > 0 && held_sorted[pos-1] > v) pos--;
      held_sorted.insert(pos, v);
    end
    n = held_sorted.size();
    k = (n + 1) / 2;
    if (n % 2 == 1) begin
      r.median_value = SW'(held_sorted[k-1]);
    end else begin
      r.median_value = SW'((held_sorted[k-1] + held_sorted[k]) >>> 1);
    end
    r.sample_count = CW'(n);
    return r;
  endfunction

  initial begin
    rst_n               = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.sample_value = '0;
    out_chan.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: a beat stays on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (!send_paused && samples_to_send.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_chan.valid        <= 1'b1;
        in_chan.sample_value <= samples_to_send.pop_front();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || recv_hold) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on each accepted sample and checks each result beat.
  always @(posedge clk) begin
    median_beat_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        medians_due.insert(medians_due.size(), predict_median(in_chan.sample_value));
      end
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (out_chan.sample_dropped) drops_seen++;
        if (medians_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat: median %0d count %0d",
                                         out_chan.median_value, out_chan.sample_count);
        end else begin
          want = medians_due.pop_front();
          if (out_chan.median_value !== want.median_value ||
              out_chan.sample_count !== want.sample_count ||
              out_chan.sample_dropped !== want.sample_dropped) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch at beat %0d: median %0d/%0d count %0d/%0d dropped %0b/%0b",
                       results_seen, out_chan.median_value, want.median_value,
                       out_chan.sample_count, want.sample_count,
                       out_chan.sample_dropped, want.sample_dropped);
            end
          end
        end
      end
    end
  end

  function automatic logic signed [SW-1:0] random_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return $urandom;
    if (sel < 7) return $signed($urandom_range(2000)) - 1000;
    if (sel < 9 && held_sorted.size() > 0)
      return SW'(held_sorted[$urandom_range(held_sorted.size() - 1)]);
    return $signed($urandom_range(65535)) <<< 16;
  endfunction

  task automatic run_phase(int count);
    repeat (count) samples_to_send.insert(samples_to_send.size(), random_sample());
    wait (samples_to_send.size() == 0);
  endtask

  // Checked between edges so that the driver and monitor updates have settled.
  task automatic wait_drained();
    while (samples_to_send.size() != 0 || in_chan.valid || medians_due.size() != 0)
      @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_paused   = 1'b0;
    recv_hold     = 1'b0;
    mismatches    = 0;
    results_seen  = 0;
    drops_seen    = 0;
    wait (rst_n);

    // Extremes, sign boundaries, ties and alternating bit patterns.
    samples_to_send = {32'sh7fffffff, 32'sh80000000, 32'sh00000000, 32'shffffffff,
                       32'sh7fffffff, 32'sh80000000, 32'sh00000001, 32'sh00010000,
                       32'shffff0000, 32'sh55555555, 32'shaaaaaaaa, 32'sh00000000,
                       32'sh00000000, 32'sh7ffffffe, 32'sh80000001, 32'sh00008000,
                       32'shffff8000, 32'sh12345678};
    wait_drained();

    send_idle_pct = 25;
    recv_idle_pct = 83;
    run_phase(240);

    // Sender holds back until every outstanding result is home.
    send_paused = 1'b1;
    wait_drained();
    send_paused = 1'b0;

    send_idle_pct = 83;
    recv_idle_pct = 25;
    fork
      run_phase(240);
      begin
        repeat (200) @(posedge clk);
        recv_hold <= 1'b1;
        repeat (400) @(posedge clk);
        recv_hold <= 1'b0;
      end
    join

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(250);
    wait_drained();

    $display("Checked %0d result beats, %0d of them dropped samples, final count %0d.",
             results_seen, drops_seen, held_sorted.size());
    if (mismatches == 0 && medians_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, medians_due.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", medians_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: two_heap_running_median.f
sv/rhm_pkg.sv
sv/rhm_if.sv
sv/rhm_ram.sv
sv/rhm_heap_engine.sv
sv/two_heap_running_median.sv
tb/tb_two_heap_running_median.sv
